### sv/pde_pkg.sv
// Package for the pulse-distance frame encoder.
// Frame size, timing register map, reset values and shared types.
// No dependencies.
package pde_pkg;

   localparam int FRAME_BITS = 32;
   localparam int FRAME_WORD_WIDTH = 32;
   localparam int DUR_WIDTH = 16;
   localparam int PAIR_COUNT = FRAME_BITS + 2;
   localparam int IDX_WIDTH = $clog2(PAIR_COUNT);
   localparam int LAST_IDX = PAIR_COUNT - 1;
   localparam int CSR_IDX_WIDTH = 3;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_LEADER_MARK  = 3'd0,
      REG_LEADER_SPACE = 3'd1,
      REG_BIT_MARK     = 3'd2,
      REG_ZERO_SPACE   = 3'd3,
      REG_ONE_SPACE    = 3'd4,
      REG_END_MARK     = 3'd5,
      REG_END_SPACE    = 3'd6
   } csr_index_type;

   typedef logic [DUR_WIDTH-1:0] dur_type;

   typedef struct packed {
      dur_type leader_mark;
      dur_type leader_space;
      dur_type bit_mark;
      dur_type zero_space;
      dur_type one_space;
      dur_type end_mark;
      dur_type end_space;
   } timing_type;

   localparam dur_type RST_LEADER_MARK  = 16'h0156;
   localparam dur_type RST_LEADER_SPACE = 16'h00AB;
   localparam dur_type RST_BIT_MARK     = 16'h0015;
   localparam dur_type RST_ZERO_SPACE   = 16'h0015;
   localparam dur_type RST_ONE_SPACE    = 16'h0040;
   localparam dur_type RST_END_MARK     = 16'h0015;
   localparam dur_type RST_END_SPACE    = 16'h08FD;

endpackage

### sv/pde_if.sv
// Handshake channel interfaces for the pulse-distance frame encoder.
// Depends on pde_pkg for field widths.
interface pde_req_if;
   import pde_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [FRAME_WORD_WIDTH-1:0] frame_word;
   modport source(output valid, output frame_word, input ready);
   modport sink(input valid, input frame_word, output ready);
endinterface

interface pde_rsp_if;
   import pde_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DUR_WIDTH-1:0] mark_time;
   logic [DUR_WIDTH-1:0] space_time;
   logic                 last_pair;
   modport source(output valid, output mark_time, output space_time, output last_pair,
                  input ready);
   modport sink(input valid, input mark_time, input space_time, input last_pair,
                output ready);
endinterface

### sv/ir_pulse_distance_encoder.sv
// Pulse-distance frame encoder, top level.
// Depends on pde_pkg, pde_req_if / pde_rsp_if and pde_csr_regs.
//
// Each accepted frame word produces FRAME_BITS + 2 (34) mark/space words on
// rsp_chan: the leader pair, one pair per data bit from bit 0 upward (a one
// takes one_space, a zero takes zero_space, all marks are bit_mark) and the
// end pair, flagged by last_pair. One word leaves per cycle unless the receiver
// stalls. The next frame word is taken in the cycle its predecessor's end pair
// moves into the output register, so frames stream back to back with no gap.
// The user must write the timing registers through csr_write_en / csr_index /
// csr_wdata only while the block is idle; the block itself does not enforce it.
module ir_pulse_distance_encoder
   import pde_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   pde_req_if.sink                  req_chan,
   pde_rsp_if.source                rsp_chan,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DUR_WIDTH-1:0]     csr_wdata
);

   timing_type timing;

   pde_csr_regs u_csr_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .timing       (timing)
   );

   logic                  active_ff, active_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [IDX_WIDTH-1:0]  index_ff, index_in;
   logic                  valid_ff, valid_in;
   dur_type               mark_ff, mark_in;
   dur_type               space_ff, space_in;
   logic                  last_ff, last_in;

   logic out_free;
   logic emit;
   logic final_pair;
   logic load;

   assign out_free   = !valid_ff || rsp_chan.ready;
   assign emit       = active_ff && out_free;
   assign final_pair = (index_ff == IDX_WIDTH'(LAST_IDX));
   assign req_chan.ready = !active_ff || (emit && final_pair);
   assign load       = req_chan.valid && req_chan.ready;

   always_comb begin
      active_in = active_ff;
      shift_in  = shift_ff;
      index_in  = index_ff;
      priority if (load) begin
         active_in = 1'b1;
         shift_in  = FRAME_BITS'(req_chan.frame_word);
         index_in  = '0;
      end else if (emit && final_pair) begin
         active_in = 1'b0;
      end else if (emit) begin
         index_in = index_ff + IDX_WIDTH'(1);
         if (index_ff != '0) begin
            shift_in = shift_ff >> 1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      mark_in  = mark_ff;
      space_in = space_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         priority if (index_ff == '0) begin
            mark_in  = timing.leader_mark;
            space_in = timing.leader_space;
            last_in  = 1'b0;
         end else if (final_pair) begin
            mark_in  = timing.end_mark;
            space_in = timing.end_space;
            last_in  = 1'b1;
         end else begin
            mark_in  = timing.bit_mark;
            space_in = shift_ff[0] ? timing.one_space : timing.zero_space;
            last_in  = 1'b0;
         end
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         index_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         index_ff  <= index_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      mark_ff  <= mark_in;
      space_ff <= space_in;
      last_ff  <= last_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.mark_time  = mark_ff;
   assign rsp_chan.space_time = space_ff;
   assign rsp_chan.last_pair  = last_ff;

   // pair counter stays within the frame
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (index_ff <= IDX_WIDTH'(LAST_IDX)))
      else $error("pair index past end pair");

   // a new frame starts with the leader
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      load |=> (active_ff && index_ff == '0))
      else $error("frame load did not restart pair counter");

   // end pair without a following frame leaves the block idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && final_pair && !load) |=> (!active_ff && valid_ff && last_ff))
      else $error("end pair not followed by idle");

   // the leader word never carries the end flag
   a_leader_flag: assert property (@(posedge clock) disable iff (reset)
      (emit && index_ff == '0) |=> (valid_ff && !last_ff))
      else $error("leader word flagged as end pair");

endmodule

### sv/pde_csr_regs.sv
// Timing register file of the pulse-distance frame encoder.
// Depends on pde_pkg; write-only, indexes beyond the map are ignored.
module pde_csr_regs
   import pde_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DUR_WIDTH-1:0]     csr_wdata,
   output timing_type               timing
);

   timing_type timing_ff;
   timing_type timing_in;

   always_comb begin
      timing_in = timing_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            REG_LEADER_MARK:  timing_in.leader_mark  = csr_wdata;
            REG_LEADER_SPACE: timing_in.leader_space = csr_wdata;
            REG_BIT_MARK:     timing_in.bit_mark     = csr_wdata;
            REG_ZERO_SPACE:   timing_in.zero_space   = csr_wdata;
            REG_ONE_SPACE:    timing_in.one_space    = csr_wdata;
            REG_END_MARK:     timing_in.end_mark     = csr_wdata;
            REG_END_SPACE:    timing_in.end_space    = csr_wdata;
            default:          timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.leader_mark  <= RST_LEADER_MARK;
         timing_ff.leader_space <= RST_LEADER_SPACE;
         timing_ff.bit_mark     <= RST_BIT_MARK;
         timing_ff.zero_space   <= RST_ZERO_SPACE;
         timing_ff.one_space    <= RST_ONE_SPACE;
         timing_ff.end_mark     <= RST_END_MARK;
         timing_ff.end_space    <= RST_END_SPACE;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule

### bench/ir_pulse_distance_encoder_tb.sv
// Testbench for ir_pulse_distance_encoder: frame words in, mark/space words out.
// Depends on pde_pkg and pde_req_if / pde_rsp_if; a scoreboard class predicts
// every timing pair from its own copy of the timing registers.
`timescale 1ns / 100ps

module ir_pulse_distance_encoder_tb;
   import pde_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_SPARE = 3'd7;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_FRAMES = 85;
   localparam logic [FRAME_WORD_WIDTH-1:0] DIRECTED_WORDS [12] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
      32'h0000_0001, 32'h8000_0000, 32'h0000_00FF, 32'hFF00_0000,
      32'hF708_FB04, 32'h00FF_00FF, 32'h1234_5678, 32'h0100_0080
   };

   typedef struct packed {
      dur_type mark_dur;
      dur_type space_dur;
      logic    end_flag;
   } pair_type;

   class pair_scoreboard;
      timing_type  timing;
      pair_type    pending_pairs[$];
      int unsigned errors;

      function new();
         timing = '{RST_LEADER_MARK, RST_LEADER_SPACE, RST_BIT_MARK, RST_ZERO_SPACE,
                    RST_ONE_SPACE, RST_END_MARK, RST_END_SPACE};
         errors = 0;
      endfunction

      // writes to an unused index are dropped
      function void write_reg(logic [CSR_IDX_WIDTH-1:0] idx, dur_type value);
         case (idx)
            REG_LEADER_MARK:  timing.leader_mark  = value;
            REG_LEADER_SPACE: timing.leader_space = value;
            REG_BIT_MARK:     timing.bit_mark     = value;
            REG_ZERO_SPACE:   timing.zero_space   = value;
            REG_ONE_SPACE:    timing.one_space    = value;
            REG_END_MARK:     timing.end_mark     = value;
            REG_END_SPACE:    timing.end_space    = value;
            default: ;
         endcase
      endfunction

      function void note_frame(logic [FRAME_WORD_WIDTH-1:0] word);
         logic [FRAME_WORD_WIDTH-1:0] rest;
         rest = word;
         pending_pairs.push_back('{timing.leader_mark, timing.leader_space, 1'b0});
         for (int b = 0; b < FRAME_BITS; b++) begin
            pending_pairs.push_back('{timing.bit_mark,
                                      rest[0] ? timing.one_space : timing.zero_space, 1'b0});
            rest = rest >> 1;
         end
         pending_pairs.push_back('{timing.end_mark, timing.end_space, 1'b1});
      endfunction

      function void check_pair(dur_type mark_time, dur_type space_time, logic last_pair);
         pair_type exp_pair;
         if (pending_pairs.size() == 0) begin
            $error("unexpected word: mark_time %0d space_time %0d last_pair %0d",
                   mark_time, space_time, last_pair);
            errors++;
            return;
         end
         exp_pair = pending_pairs.pop_front();
         if (mark_time !== exp_pair.mark_dur) begin
            $error("mark_time: expected %0d, actual %0d", exp_pair.mark_dur, mark_time);
            errors++;
         end
         if (space_time !== exp_pair.space_dur) begin
            $error("space_time: expected %0d, actual %0d", exp_pair.space_dur, space_time);
            errors++;
         end
         if (last_pair !== exp_pair.end_flag) begin
            $error("last_pair: expected %0d, actual %0d", exp_pair.end_flag, last_pair);
            errors++;
         end
      endfunction

      function int pending();
         return pending_pairs.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_write_en;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [DUR_WIDTH-1:0]     csr_wdata;

   pde_req_if req_chan();
   pde_rsp_if rsp_chan();

   pair_scoreboard sb;
   int unsigned    send_idle_pct;
   int unsigned    recv_stall_pct;
   int unsigned    holds_asked;
   int unsigned    holds_served;
   int unsigned    hold_left;

   ir_pulse_distance_encoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_chan.ready = 1'b0;
      holds_served = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_frame(req_chan.frame_word);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_pair(rsp_chan.mark_time, rsp_chan.space_time, rsp_chan.last_pair);
      end
   end

   // caller sits at a rising edge; valid stays high on return
   task automatic send_frame(input logic [FRAME_WORD_WIDTH-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.frame_word <= $urandom;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.frame_word <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic reg_write(input logic [CSR_IDX_WIDTH-1:0] idx, input dur_type value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic program_timing(input timing_type t, input bit poke_spare);
      reg_write(REG_LEADER_MARK, t.leader_mark);
      reg_write(REG_LEADER_SPACE, t.leader_space);
      reg_write(REG_BIT_MARK, t.bit_mark);
      if (poke_spare) reg_write(CSR_IDX_SPARE, dur_type'($urandom));
      reg_write(REG_ZERO_SPACE, t.zero_space);
      reg_write(REG_ONE_SPACE, t.one_space);
      reg_write(REG_END_MARK, t.end_mark);
      reg_write(REG_END_SPACE, t.end_space);
      csr_write_en <= 1'b0;
   endtask

   function automatic dur_type pick_duration();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return dur_type'($urandom_range(255));
         default: return dur_type'($urandom);
      endcase
   endfunction

   function automatic logic [FRAME_WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(4))
         0: return $urandom & $urandom;
         1: return $urandom | $urandom;
         2: return 32'h1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      timing_type t;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.frame_word = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      holds_asked = 0;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing, then the extremes and alternating bit patterns
      foreach (DIRECTED_WORDS[i]) send_frame(DIRECTED_WORDS[i]);
      drain();
      program_timing('0, 1'b1);
      for (int i = 0; i < 3; i++) send_frame(DIRECTED_WORDS[i + 1]);
      drain();
      program_timing('1, 1'b1);
      for (int i = 0; i < 3; i++) send_frame(DIRECTED_WORDS[i + 2]);
      drain();
      program_timing('{16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h7FFE, 16'hA5A5,
                       16'h5A5A}, 1'b0);
      for (int i = 0; i < 3; i++) send_frame(DIRECTED_WORDS[i + 8]);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         t = '{pick_duration(), pick_duration(), pick_duration(), pick_duration(),
               pick_duration(), pick_duration(), pick_duration()};
         program_timing(t, 1'($urandom_range(1)));
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            // block fills up while the receiver holds off
            if (phase == 0 && n == 10) holds_asked++;
            // stretches with no idling inside the idling phases
            if (phase != 0 && n == PHASE_FRAMES / 2) begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            send_frame(pick_word());
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
